>>> rtl/set_assoc_cache_tag_lru_assert.svh
// Assertion macros for the cache tag and LRU controller.
`ifndef SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_ASSERT_SVH
`ifndef ASSERT_OFF
`define SACTL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sactl assertion failed");
`define SACTL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sactl assertion failed");
`else
`define SACTL_ASSERT(lbl, clk, rst_n, prop)
`define SACTL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/sactl_pkg.sv
// Shared types and constants for the cache tag and LRU controller.
package sactl_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_INVAL = 2'd2;

    localparam logic [48:0] MEM_BYTES_RESET = 49'd16777216;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] address;
        logic [6:0]  length;
    } t_in;

    typedef struct packed {
        logic        rejected;
        logic        hit;
        logic [1:0]  way_used;
        logic        writeback_valid;
        logic [47:0] writeback_line;
        logic        fill_valid;
    } t_out;

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/sactl_ctrl.sv
// Controller state machine: tag clear sweep, transfer accept, row commit.
module sactl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sactl_pkg::t_sts  i_sts,
    output sactl_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clear_last) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (!i_sts.out_busy) r_state <= ST_IDLE;
                end
                default: r_state <= ST_CLEAR;
            endcase
        end
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.clear_we = (r_state == ST_CLEAR);
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.commit   = (r_state == ST_EVAL) && !i_sts.out_busy;
    end

endmodule

>>> rtl/sactl_dp.sv
// Datapath: tag row memory, hit and victim logic, LRU update, result register.
module sactl_dp #(
    parameter int SETS       = 64,
    parameter int WAYS       = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [48:0]      i_cfg_data,
    input  sactl_pkg::t_in   i_in,
    output sactl_pkg::t_out  o_out,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sactl_pkg::t_cmd  i_cmd,
    output sactl_pkg::t_sts  o_sts
);

    localparam int OFF     = $clog2(LINE_BYTES);
    localparam int SL      = $clog2(SETS);
    localparam int SB      = (SL > 0) ? SL : 1;
    localparam int AW      = (ADDR_BITS < 48) ? ADDR_BITS : 48;
    localparam int TAG_RAW = AW - OFF - SL;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [47:0] AMASK = (AW >= 48) ? {48{1'b1}} : ((48'd1 << AW) - 48'd1);
    localparam logic [47:0] LMASK = ~(48'(LINE_BYTES) - 48'd1);

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [WB-1:0]    rank;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    t_row r_mem [SETS];
    t_row r_rd;

    logic [47:0]     r_addr;
    logic [1:0]      r_func;
    logic [6:0]      r_len;
    logic [SB-1:0]   r_clr_set;
    logic [48:0]     r_mem_bytes;
    sactl_pkg::t_out r_out;
    logic            r_out_valid;

    logic [47:0]      in_addr_m;
    logic [SB-1:0]    in_set;
    logic [47:0]      line_no;
    logic [SB-1:0]    set;
    logic [TAG_W-1:0] tag;
    t_row             c_rst_row;
    logic [WAYS-1:0]  match;
    logic             hit;
    logic [WB-1:0]    found;
    logic [WB-1:0]    victim;
    logic [WB-1:0]    sel;
    logic [WB-1:0]    old_rank;
    t_row             n_new;
    t_row             n_row;
    logic [48:0]      sum;
    logic             over;
    logic             len_bad;
    logic [47:0]      wb_addr;
    logic             wb_ok;
    logic [47:0]      line_addr;
    logic             fill;
    sactl_pkg::t_out  n_out;

    assign in_addr_m = i_in.address & AMASK;
    assign in_set    = SB'(in_addr_m >> OFF) & SB'(SETS - 1);
    assign line_no   = r_addr >> OFF;
    assign set       = SB'(line_no) & SB'(SETS - 1);
    assign tag       = TAG_W'(line_no >> SL);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            c_rst_row[w].valid = 1'b0;
            c_rst_row[w].dirty = 1'b0;
            c_rst_row[w].tag   = '0;
            c_rst_row[w].rank  = WB'(w);
        end
    end

    always_comb begin
        found  = '0;
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = r_rd[w].valid && (r_rd[w].tag == tag);
            if (match[w]) found = WB'(w);
            if (r_rd[w].rank == '0) victim = WB'(w);
        end
        hit      = |match;
        sel      = hit ? found : victim;
        old_rank = r_rd[sel].rank;
        for (int w = 0; w < WAYS; w++) begin
            n_new[w] = r_rd[w];
            if (r_rd[w].rank > old_rank) n_new[w].rank = r_rd[w].rank - WB'(1);
        end
        n_new[sel].rank = WB'(WAYS - 1);
    end

    always_comb begin
        sum       = 49'(r_addr) + 49'(r_len);
        over      = sum > r_mem_bytes;
        len_bad   = 9'(r_len) > 9'(LINE_BYTES);
        wb_addr   = (48'(r_rd[victim].tag) << (SL + OFF)) | (48'(set) << OFF);
        wb_ok     = r_rd[victim].valid && r_rd[victim].dirty
                    && (49'(wb_addr) < r_mem_bytes);
        line_addr = r_addr & LMASK;
        fill      = 49'(line_addr) < r_mem_bytes;
    end

    always_comb begin
        n_out = '0;
        n_row = r_rd;
        unique case (r_func)
            sactl_pkg::FUNC_INVAL: begin
                n_out.hit = hit;
                if (hit) begin
                    n_out.way_used     = 2'(found);
                    n_row[found].valid = 1'b0;
                    n_row[found].dirty = 1'b0;
                end
            end
            sactl_pkg::FUNC_READ, sactl_pkg::FUNC_WRITE: begin
                if (len_bad || over) begin
                    n_out.rejected = 1'b1;
                end else if (hit) begin
                    n_row          = n_new;
                    n_out.hit      = 1'b1;
                    n_out.way_used = 2'(found);
                    if (r_func == sactl_pkg::FUNC_WRITE) n_row[found].dirty = 1'b1;
                end else begin
                    n_row                 = n_new;
                    n_row[victim].valid   = 1'b1;
                    n_row[victim].tag     = tag;
                    n_row[victim].dirty   = (r_func == sactl_pkg::FUNC_WRITE);
                    n_out.way_used        = 2'(victim);
                    n_out.writeback_valid = wb_ok;
                    n_out.writeback_line  = wb_ok ? wb_addr : '0;
                    n_out.fill_valid      = fill;
                end
            end
            default: n_out.rejected = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_we) begin
            r_mem[r_clr_set] <= c_rst_row;
        end else if (i_cmd.commit) begin
            r_mem[set] <= n_row;
        end
        if (i_cmd.accept) begin
            r_rd   <= r_mem[in_set];
            r_addr <= in_addr_m;
            r_func <= i_in.func;
            r_len  <= i_in.length;
        end
        if (i_cmd.commit) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_set   <= '0;
            r_out_valid <= 1'b0;
            r_mem_bytes <= sactl_pkg::MEM_BYTES_RESET;
        end else begin
            if (i_cmd.clear_we) r_clr_set <= r_clr_set + SB'(1);
            if (i_cfg_we) r_mem_bytes <= i_cfg_data;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clear_last = (r_clr_set == SB'(SETS - 1));
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
    assign o_out            = r_out;
    assign o_out_valid      = r_out_valid;

endmodule

>>> rtl/set_assoc_cache_tag_lru.sv
// Top level of the set-associative cache tag and LRU replacement controller.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_in  (func, address, length)
//   result    out        o_out_valid / i_out_ready  o_out (rejected .. fill_valid)
//   config    in         i_cfg_we                   i_cfg_data (memory_bytes)
//
// Items are taken one at a time: the set's tag row is read at the accept edge,
// then evaluated and written back through the one-port row memory.
// After reset a clearing pass writes every set, with o_in_ready low.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in evaluation while that register is still occupied.
`include "set_assoc_cache_tag_lru_assert.svh"

module set_assoc_cache_tag_lru #(
    parameter int SETS       = 64,
    parameter int WAYS       = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [48:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sactl_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sactl_pkg::t_out  o_out
);

    sactl_pkg::t_cmd cmd;
    sactl_pkg::t_sts sts;

    sactl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sactl_dp #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    `SACTL_ASSERT(a_accept_commit_excl, i_clk, i_rst_n, !(cmd.accept && cmd.commit))
    `SACTL_ASSERT(a_commit_fills_out, i_clk, i_rst_n, cmd.commit |=> o_out_valid)
    `SACTL_ASSERT(a_no_back_to_back, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `SACTL_ASSERT_ALWAYS(a_reset_empties_out, i_clk, !i_rst_n |=> !o_out_valid)

endmodule
